[rtl/core/segment_l2_cost_prefix_sums_top_assert.svh]
// Assertion macros for the segment L2 cost engine.
`ifndef SEGMENT_L2_COST_PREFIX_SUMS_TOP_ASSERT_SVH
`define SEGMENT_L2_COST_PREFIX_SUMS_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent in one cycle implies consequent in the next cycle.
`define SLCPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
// Expression holds at every clock edge out of reset.
`define SLCPS_ASSERT_NOW(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("same-cycle check failed");
`else
`define SLCPS_ASSERT_NEXT(lbl, ante, cons)
`define SLCPS_ASSERT_NOW(lbl, expr)
`endif
`endif

[rtl/core/slcps_pkg.sv]
// Shared types and constants of the segment L2 cost engine.
`default_nettype none
package slcps_pkg;

    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int COST_W        = 42;
    localparam int MEAN_W        = 16;
    localparam int COLIDX_W      = 2;
    localparam int PORT_SAMPLE_W = 16;
    localparam int PORT_COLS     = 4;
    localparam int START_W       = 10;
    localparam int END_W         = 11;
    localparam int CFG_W         = 3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SEG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_COST   = 2'd1,
        FUNC_MEAN   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_APP,
        S_COMMIT,
        S_RD_END,
        S_RD_START,
        S_CAP,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_GO,
        S_DIV,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic app_step;
        logic app_commit;
        logic rd_end;
        logic rd_start;
        logic cap_start;
        logic diff;
        logic mul_lo;
        logic mul_hi;
        logic div_go;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t func;
        logic  full;
        logic  bad;
        logic  short_seg;
        logic  app_last;
        logic  col_last;
        logic  div_done;
        logic  out_free;
    } sts_t;

endpackage
`default_nettype wire

[rtl/core/slcps_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module slcps_div
    import slcps_pkg::*;
#(
    parameter int NUM_W = 54,
    parameter int DEN_W = 11
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    // Sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, divisor}) : DEN_W'(trial);
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/core/slcps_datapath.sv]
// Datapath: prefix stores, column arithmetic, divider and result register.
`default_nettype none
module slcps_datapath
    import slcps_pkg::*;
#(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 4,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    output sts_t                            sts,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_W-1:0]           cfg_wdata,
    input  wire logic [FUNC_W-1:0]          func,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col0,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col1,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col2,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col3,
    input  wire logic [START_W-1:0]         seg_start,
    input  wire logic [END_W-1:0]           seg_end,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [STATUS_W-1:0]             status,
    output logic [COST_W-1:0]               seg_cost,
    output logic signed [MEAN_W-1:0]        mean_value,
    output logic [COLIDX_W-1:0]             column_index,
    output logic                            last
);

    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DW     = SAMPLE_BITS - 1 + ROW_W;
    localparam int SUM_W  = DW + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 2 + ROW_W;
    localparam int SQA_W  = SQ_W + 2;
    localparam int H      = (DW + 1) / 2;
    localparam int NORM_W = 2 * DW + 2;
    localparam int CMP_W  = (ROW_W > END_W) ? ROW_W : END_W;
    localparam int CW     = (NORM_W > COST_W) ? NORM_W : COST_W;
    localparam int XW     = (SAMPLE_BITS > PORT_SAMPLE_W) ? SAMPLE_BITS : PORT_SAMPLE_W;

    // Prefix stores; row zero is never written and reads as zero.
    logic [MAX_COLS-1:0][SUM_W-1:0] sum_mem [MAX_ROWS+1];
    logic [MAX_COLS-1:0][SQ_W-1:0]  sq_mem  [MAX_ROWS+1];

    logic [CFG_W-1:0]  cols_reg;
    logic [CFG_W-1:0]  nc;
    logic [ROW_W-1:0]  rows_reg;
    logic [MAX_COLS-1:0][SUM_W-1:0] last_sum_reg;
    logic [MAX_COLS-1:0][SQ_W-1:0]  last_sq_reg;

    func_t             func_reg;
    logic [PORT_COLS-1:0][PORT_SAMPLE_W-1:0] samp_in;
    logic [PORT_COLS-1:0][PORT_SAMPLE_W-1:0] samp_reg;
    logic [END_W-1:0]  end_reg;
    logic [START_W-1:0] start_reg;
    logic              full_reg;
    logic              bad_reg;
    logic              short_reg;
    logic [ROW_W-1:0]  len_reg;
    logic [CI_W-1:0]   col_reg;

    logic [ROW_W-1:0]  rd_addr;
    logic              rd_en;
    logic [MAX_COLS-1:0][SUM_W-1:0] rd_sum_reg;
    logic [MAX_COLS-1:0][SQ_W-1:0]  rd_sq_reg;
    logic              rd_zero_reg;
    logic [MAX_COLS-1:0][SUM_W-1:0] rd_sum_row;
    logic [MAX_COLS-1:0][SQ_W-1:0]  rd_sq_row;
    logic [MAX_COLS-1:0][SUM_W-1:0] end_sum_reg;
    logic [MAX_COLS-1:0][SQ_W-1:0]  end_sq_reg;
    logic [MAX_COLS-1:0][SUM_W-1:0] start_sum_reg;
    logic [MAX_COLS-1:0][SQ_W-1:0]  start_sq_reg;

    logic [CMP_W-1:0]  end_ext;
    logic [CMP_W-1:0]  start_ext;
    logic [CMP_W-1:0]  len_ext;

    logic [PORT_SAMPLE_W-1:0] samp_sel;
    logic [XW-1:0]     raw_x;
    logic              use_col;
    logic signed [SAMPLE_BITS-1:0] x_eff;
    logic [SAMPLE_BITS-1:0] ax;
    logic [2*SAMPLE_BITS-1:0] sq_x;

    logic signed [SUM_W:0] d_full;
    logic              d_neg_reg;
    logic [DW-1:0]     d_mag_reg;
    logic [SQA_W-1:0]  sq_acc_reg;
    logic [NORM_W-1:0] norm_acc_reg;
    logic [H-1:0]      op_b;
    logic [DW+H-1:0]   prod;
    logic [NORM_W-1:0] addend;

    logic [NORM_W-1:0] div_num;
    logic              div_done;
    logic [NORM_W-1:0] quo;

    logic [CW-1:0]     sq_ext;
    logic [CW-1:0]     quo_ext;
    logic [CW-1:0]     cost_diff;
    logic [COST_W-1:0] cost_val;
    logic [MEAN_W-1:0] q_trunc;

    logic              out_valid_reg;
    logic [STATUS_W-1:0] res_status;
    logic [COST_W-1:0] res_cost;
    logic [MEAN_W-1:0] res_mean;
    logic [COLIDX_W-1:0] res_col;
    logic              res_last;
    logic [STATUS_W-1:0] status_reg;
    logic [COST_W-1:0] cost_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [COLIDX_W-1:0] col_out_reg;
    logic              last_reg;

    assign samp_in = {sample_col3, sample_col2, sample_col1, sample_col0};

    // Effective column count: zero acts as one, too large acts as the maximum.
    always_comb
    begin
        if (cols_reg == '0)
            nc = CFG_W'(1);
        else if (cols_reg > CFG_W'(MAX_COLS))
            nc = CFG_W'(MAX_COLS);
        else
            nc = cols_reg;
    end

    // Segment bound checks on the incoming item.
    assign end_ext   = CMP_W'(seg_end);
    assign start_ext = CMP_W'(seg_start);
    assign len_ext   = end_ext - start_ext;

    // Append: pick one column sample, read it as a SAMPLE_BITS signed value and square its magnitude.
    assign samp_sel = samp_reg[col_reg];
    assign raw_x    = XW'(samp_sel);
    assign use_col  = CFG_W'(col_reg) < nc;
    assign x_eff    = use_col ? $signed(raw_x[SAMPLE_BITS-1:0]) : '0;
    assign ax       = x_eff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_eff) : SAMPLE_BITS'(x_eff);
    assign sq_x     = ax * ax;

    // Store read port.
    assign rd_en   = cmd.rd_end | cmd.rd_start;
    assign rd_addr = cmd.rd_end ? ROW_W'(end_reg) : ROW_W'(start_reg);
    assign rd_sum_row = rd_zero_reg ? '0 : rd_sum_reg;
    assign rd_sq_row  = rd_zero_reg ? '0 : rd_sq_reg;

    // Column difference of the segment sum.
    assign d_full = $signed({end_sum_reg[col_reg][SUM_W-1], end_sum_reg[col_reg]})
                  - $signed({start_sum_reg[col_reg][SUM_W-1], start_sum_reg[col_reg]});

    // Square of the difference in two halves through one multiplier.
    assign op_b   = cmd.mul_hi ? H'(d_mag_reg[DW-1:H]) : d_mag_reg[H-1:0];
    assign prod   = d_mag_reg * op_b;
    assign addend = cmd.mul_hi ? (NORM_W'(prod) << H) : NORM_W'(prod);

    assign div_num = (func_reg == FUNC_COST) ? norm_acc_reg : NORM_W'(d_mag_reg);

    slcps_div #(
        .NUM_W (NORM_W),
        .DEN_W (ROW_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (div_num),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Final cost with saturation, and the truncated mean.
    assign sq_ext    = CW'(sq_acc_reg);
    assign quo_ext   = CW'(quo);
    assign cost_diff = (sq_ext >= quo_ext) ? (sq_ext - quo_ext) : '0;
    assign cost_val  = (cost_diff > CW'(COST_MAX)) ? COST_MAX : COST_W'(cost_diff);
    assign q_trunc   = MEAN_W'(quo);

    // Result selection.
    always_comb
    begin
        res_status = ST_OK;
        res_cost   = '0;
        res_mean   = '0;
        res_col    = '0;
        res_last   = 1'b1;
        if (func_reg == FUNC_APPEND)
        begin
            res_status = full_reg ? ST_FULL : ST_OK;
        end
        else if (bad_reg)
        begin
            res_status = ST_BAD_SEG;
        end
        else if (func_reg == FUNC_COST)
        begin
            res_cost = short_reg ? '0 : cost_val;
        end
        else
        begin
            res_mean = d_neg_reg ? (-q_trunc) : q_trunc;
            res_col  = COLIDX_W'(col_reg);
            res_last = sts.col_last;
        end
    end

    // Control state: configuration, fill count, last prefix row, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= CFG_W'(1);
            rows_reg      <= '0;
            last_sum_reg  <= '0;
            last_sq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cols_reg <= cfg_wdata;
            if (cmd.app_step)
            begin
                last_sum_reg[col_reg] <= SUM_W'($signed(last_sum_reg[col_reg])
                                         + SUM_W'(x_eff));
                last_sq_reg[col_reg]  <= last_sq_reg[col_reg] + SQ_W'(sq_x);
            end
            if (cmd.app_commit)
                rows_reg <= rows_reg + ROW_W'(1);
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Item registers, column sequencing, accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func_t'(func);
            samp_reg   <= samp_in;
            end_reg    <= seg_end;
            start_reg  <= seg_start;
            full_reg   <= rows_reg == ROW_W'(MAX_ROWS);
            bad_reg    <= (start_ext >= end_ext) || (end_ext > CMP_W'(rows_reg));
            short_reg  <= len_ext < CMP_W'(2);
            len_reg    <= ROW_W'(len_ext);
            col_reg    <= '0;
            sq_acc_reg <= '0;
            norm_acc_reg <= '0;
        end
        else
        begin
            if (cmd.app_step || cmd.mul_hi || (cmd.emit && func_reg == FUNC_MEAN))
                col_reg <= col_reg + CI_W'(1);
            if (cmd.diff)
            begin
                d_neg_reg  <= d_full < 0;
                d_mag_reg  <= (d_full < 0) ? DW'(-d_full) : DW'(d_full);
                sq_acc_reg <= sq_acc_reg
                            + SQA_W'(end_sq_reg[col_reg] - start_sq_reg[col_reg]);
            end
            if (cmd.mul_lo || cmd.mul_hi)
                norm_acc_reg <= norm_acc_reg + addend;
        end
        if (cmd.rd_start)
        begin
            end_sum_reg <= rd_sum_row;
            end_sq_reg  <= rd_sq_row;
        end
        if (cmd.cap_start)
        begin
            start_sum_reg <= rd_sum_row;
            start_sq_reg  <= rd_sq_row;
        end
    end

    // Prefix store memory with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.app_commit)
        begin
            sum_mem[ROW_W'(rows_reg + ROW_W'(1))] <= last_sum_reg;
            sq_mem[ROW_W'(rows_reg + ROW_W'(1))]  <= last_sq_reg;
        end
        if (rd_en)
        begin
            rd_sum_reg  <= sum_mem[rd_addr];
            rd_sq_reg   <= sq_mem[rd_addr];
            rd_zero_reg <= rd_addr == '0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg  <= res_status;
            cost_reg    <= res_cost;
            mean_reg    <= res_mean;
            col_out_reg <= res_col;
            last_reg    <= res_last;
        end
    end

    assign sts.func      = func_reg;
    assign sts.full      = full_reg;
    assign sts.bad       = bad_reg;
    assign sts.short_seg = short_reg;
    assign sts.app_last  = col_reg == CI_W'(MAX_COLS - 1);
    assign sts.col_last  = (CFG_W'(col_reg) + CFG_W'(1)) == nc;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign seg_cost     = cost_reg;
    assign mean_value   = $signed(mean_reg);
    assign column_index = col_out_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

[rtl/core/slcps_ctrl.sv]
// Controller state machine sequencing appends and queries.
`default_nettype none
module slcps_ctrl
    import slcps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DEC;
            S_DEC:
                unique case (sts.func)
                    FUNC_APPEND: state_next = sts.full ? S_EMIT : S_APP;
                    FUNC_COST:   state_next = sts.bad ? S_EMIT : S_RD_END;
                    FUNC_MEAN:   state_next = sts.bad ? S_EMIT : S_RD_END;
                    FUNC_NONE:   state_next = S_IDLE;
                endcase
            S_APP:
                if (sts.app_last)
                    state_next = S_COMMIT;
            S_COMMIT:
                state_next = S_EMIT;
            S_RD_END:
                state_next = S_RD_START;
            S_RD_START:
                state_next = S_CAP;
            S_CAP:
                state_next = (sts.func == FUNC_COST && sts.short_seg) ? S_EMIT : S_DIFF;
            S_DIFF:
                state_next = (sts.func == FUNC_COST) ? S_MUL_LO : S_DIV_GO;
            S_MUL_LO:
                state_next = S_MUL_HI;
            S_MUL_HI:
                state_next = sts.col_last ? S_DIV_GO : S_DIFF;
            S_DIV_GO:
                state_next = S_DIV;
            S_DIV:
                if (sts.div_done)
                    state_next = S_EMIT;
            S_EMIT:
                if (sts.out_free)
                begin
                    if (sts.func == FUNC_MEAN && !sts.bad && !sts.col_last)
                        state_next = S_DIFF;
                    else
                        state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:     cmd.load       = in_valid;
            S_DEC:      cmd            = '0;
            S_APP:      cmd.app_step   = 1'b1;
            S_COMMIT:   cmd.app_commit = 1'b1;
            S_RD_END:   cmd.rd_end     = 1'b1;
            S_RD_START: cmd.rd_start   = 1'b1;
            S_CAP:      cmd.cap_start  = 1'b1;
            S_DIFF:     cmd.diff       = 1'b1;
            S_MUL_LO:   cmd.mul_lo     = 1'b1;
            S_MUL_HI:   cmd.mul_hi     = 1'b1;
            S_DIV_GO:   cmd.div_go     = 1'b1;
            S_DIV:      cmd            = '0;
            S_EMIT:     cmd.emit       = sts.out_free;
            default:    cmd            = '0;
        endcase
    end

    assign in_stall = state_reg != S_IDLE;

endmodule
`default_nettype wire

[rtl/core/segment_l2_cost_prefix_sums_top.sv]
// An append steps through all MAX_COLS columns, one column per cycle, then commits the row.
// A cost query runs DIFF, MUL_LO and MUL_HI for each column, then one division of NORM bits,
// NORM = 2*(SAMPLE_BITS+ROW_W) (54 by default), in the restoring divider, one quotient bit per cycle.
// A mean query runs one division per column and emits one result per column.
// One transaction is in work at a time; a result register lets the next item enter.
// Reset clears the fill count and the running row; row zero reads as zero, no clear pass.
`default_nettype none
`include "segment_l2_cost_prefix_sums_top_assert.svh"
module segment_l2_cost_prefix_sums_top
    import slcps_pkg::*;
#(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 4,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [CFG_W-1:0]                cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [FUNC_W-1:0]               func,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col0,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col1,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col2,
    input  wire logic signed [PORT_SAMPLE_W-1:0] sample_col3,
    input  wire logic [START_W-1:0]              seg_start,
    input  wire logic [END_W-1:0]                seg_end,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [STATUS_W-1:0]                  status,
    output logic [COST_W-1:0]                    seg_cost,
    output logic signed [MEAN_W-1:0]             mean_value,
    output logic [COLIDX_W-1:0]                  column_index,
    output logic                                 last
);

    cmd_t cmd;
    sts_t sts;

    // Controller.
    slcps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    slcps_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (func),
        .sample_col0  (sample_col0),
        .sample_col1  (sample_col1),
        .sample_col2  (sample_col2),
        .sample_col3  (sample_col3),
        .seg_start    (seg_start),
        .seg_end      (seg_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .seg_cost     (seg_cost),
        .mean_value   (mean_value),
        .column_index (column_index),
        .last         (last)
    );

    // An accepted transaction makes the block busy in the next cycle.
    `SLCPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // A loaded result is presented in the next cycle.
    `SLCPS_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)
    // A bad-segment result carries no cost or mean and ends its transaction.
    `SLCPS_ASSERT_NOW(a_bad_seg_clean,
        !(out_valid && status == ST_BAD_SEG) || (seg_cost == '0 && mean_value == '0 && last))

endmodule
`default_nettype wire
